>>> rtl/psps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package psps_pkg;

  // defaults for the top-level parameters
  localparam int POLL_DIVIDER_DEF   = 20;
  localparam int FINGER_SENSORS_DEF = 4;

  // fixed sensor map
  localparam int LOGIC_SENSORS = 3;
  localparam int TEMP_SLOTS    = 3;

  localparam logic [6:0] FINGER_ADDR_BASE = 7'h44;
  localparam logic [7:0] FINGER_REG       = 8'h04;
  localparam logic [6:0] LOGIC_ADDR       = 7'h43;
  localparam logic [7:0] LOGIC_REG_BASE   = 8'h01;

  // stream and register port widths
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  // input item kinds
  typedef enum logic [1:0] {
    KIND_TICK = 2'd0,
    KIND_BYTE = 2'd1,
    KIND_NACK = 2'd2,
    KIND_ADC  = 2'd3
  } psps_kind_t;

  // one input item
  typedef struct packed {
    psps_kind_t  kind;
    logic [7:0]  rx_byte;
    logic [1:0]  adc_channel;
    logic [11:0] adc_value;
  } psps_item_t;

  // what one item asks of the output side
  typedef struct packed {
    logic       act;      // item produces results
    logic       status;   // 1 status run, 0 read command
    logic [6:0] addr;
    logic [7:0] reg_idx;
  } psps_desc_t;

endpackage

`default_nettype wire

>>> rtl/psps_core.sv
`timescale 1ns / 1ps
`default_nettype none

module psps_core #(
  parameter int POLL_DIVIDER   = 20,
  parameter int FINGER_SENSORS = 4
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire  [15:0]           autosend_period,
  input  psps_pkg::psps_item_t  item,
  input  wire                   consume,
  output psps_pkg::psps_desc_t  desc,
  input  wire  [3:0]            stat_idx,
  output logic [15:0]           stat_value
);
  import psps_pkg::*;

  localparam int TOTAL = FINGER_SENSORS + LOGIC_SENSORS;
  localparam int SW    = $clog2(TOTAL);
  localparam int PW    = (POLL_DIVIDER > 1) ? $clog2(POLL_DIVIDER) : 1;
  localparam int FW    = (FINGER_SENSORS > 1) ? $clog2(FINGER_SENSORS) : 1;

  logic [PW-1:0] poll_phase_r, poll_phase_nxt;
  logic [15:0]   send_phase_r, send_phase_nxt;
  logic          send_pending_r, send_pending_nxt;
  logic          read_busy_r, read_busy_nxt;
  logic          bytes_seen_r, bytes_seen_nxt;
  logic [7:0]    high_byte_r, high_byte_nxt;
  logic [SW-1:0] sensor_step_r, sensor_step_nxt;

  logic [15:0] finger_r [FINGER_SENSORS];
  logic [15:0] logic_r  [LOGIC_SENSORS];
  logic [11:0] temp_r   [TEMP_SLOTS];

  logic          finger_we, logic_we, temp_we;
  logic [15:0]   word;
  logic [15:0]   logic_ma;
  logic [PW:0]   poll_sum;
  logic [16:0]   send_sum;
  logic [SW:0]   step_sum;
  logic [SW-1:0] logic_sel;
  logic [3:0]    stat_lidx;
  logic [3:0]    stat_tidx;

  // read command for one sensor of the poll
  function automatic psps_desc_t mk_read(input logic [SW-1:0] s);
    psps_desc_t   d;
    logic [SW-1:0] l;
    d.act    = 1'b1;
    d.status = 1'b0;
    l        = s - SW'(FINGER_SENSORS);
    if (s < SW'(FINGER_SENSORS)) begin
      d.addr    = FINGER_ADDR_BASE + 7'(s);
      d.reg_idx = FINGER_REG;
    end else begin
      d.addr    = LOGIC_ADDR;
      d.reg_idx = LOGIC_REG_BASE + {5'b0, l[1:0], 1'b0};
    end
    return d;
  endfunction

  assign word      = {high_byte_r, item.rx_byte};
  assign logic_ma  = {1'b0, word[15:3], 2'b00};
  assign poll_sum  = {1'b0, poll_phase_r} + (PW+1)'(1);
  assign send_sum  = {1'b0, send_phase_r} + 17'd1;
  assign step_sum  = {1'b0, sensor_step_r} + (SW+1)'(1);
  assign logic_sel = sensor_step_r - SW'(FINGER_SENSORS);

  // per-item state update and result request
  always_comb begin
    poll_phase_nxt   = poll_phase_r;
    send_phase_nxt   = send_phase_r;
    send_pending_nxt = send_pending_r;
    read_busy_nxt    = read_busy_r;
    bytes_seen_nxt   = bytes_seen_r;
    high_byte_nxt    = high_byte_r;
    sensor_step_nxt  = sensor_step_r;
    finger_we        = 1'b0;
    logic_we         = 1'b0;
    temp_we          = 1'b0;
    desc             = '0;
    unique case (item.kind)
      KIND_TICK: begin
        if (autosend_period == 16'd0) begin
          send_phase_nxt = 16'd0;
        end else if (send_sum >= {1'b0, autosend_period}) begin
          send_phase_nxt   = 16'd0;
          send_pending_nxt = 1'b1;
        end else begin
          send_phase_nxt = send_sum[15:0];
        end
        if (poll_sum >= (PW+1)'(POLL_DIVIDER)) begin
          poll_phase_nxt  = '0;
          sensor_step_nxt = '0;
          read_busy_nxt   = 1'b1;
          bytes_seen_nxt  = 1'b0;
          desc            = mk_read('0);
        end else begin
          poll_phase_nxt = poll_sum[PW-1:0];
        end
      end
      KIND_BYTE: begin
        if (read_busy_r) begin
          if (!bytes_seen_r) begin
            high_byte_nxt  = item.rx_byte;
            bytes_seen_nxt = 1'b1;
          end else begin
            bytes_seen_nxt = 1'b0;
            finger_we      = sensor_step_r < SW'(FINGER_SENSORS);
            logic_we       = !finger_we;
            if (step_sum < (SW+1)'(TOTAL)) begin
              sensor_step_nxt = step_sum[SW-1:0];
              desc            = mk_read(step_sum[SW-1:0]);
            end else begin
              read_busy_nxt   = 1'b0;
              sensor_step_nxt = '0;
              if (send_pending_r) begin
                send_pending_nxt = 1'b0;
                desc.act         = 1'b1;
                desc.status      = 1'b1;
              end
            end
          end
        end
      end
      KIND_NACK: begin
        read_busy_nxt  = 1'b0;
        bytes_seen_nxt = 1'b0;
      end
      KIND_ADC: begin
        temp_we = item.adc_channel != 2'd3;
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_phase_r   <= '0;
      send_phase_r   <= '0;
      send_pending_r <= 1'b0;
      read_busy_r    <= 1'b0;
      bytes_seen_r   <= 1'b0;
      high_byte_r    <= '0;
      sensor_step_r  <= '0;
    end else if (consume) begin
      poll_phase_r   <= poll_phase_nxt;
      send_phase_r   <= send_phase_nxt;
      send_pending_r <= send_pending_nxt;
      read_busy_r    <= read_busy_nxt;
      bytes_seen_r   <= bytes_seen_nxt;
      high_byte_r    <= high_byte_nxt;
      sensor_step_r  <= sensor_step_nxt;
    end
  end

  // measurement registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < FINGER_SENSORS; i++) finger_r[i] <= '0;
      for (int i = 0; i < LOGIC_SENSORS; i++) logic_r[i] <= '0;
      for (int i = 0; i < TEMP_SLOTS; i++) temp_r[i] <= '0;
    end else if (consume) begin
      if (finger_we) finger_r[sensor_step_r[FW-1:0]] <= word;
      if (logic_we) logic_r[logic_sel[1:0]] <= logic_ma;
      if (temp_we) temp_r[item.adc_channel] <= item.adc_value;
    end
  end

  // status word readout
  assign stat_lidx = stat_idx - 4'(FINGER_SENSORS);
  assign stat_tidx = stat_idx - 4'(FINGER_SENSORS + LOGIC_SENSORS);

  always_comb begin
    if (stat_idx < 4'(FINGER_SENSORS)) begin
      stat_value = finger_r[stat_idx[FW-1:0]];
    end else if (stat_idx < 4'(FINGER_SENSORS + LOGIC_SENSORS)) begin
      stat_value = logic_r[stat_lidx[1:0]];
    end else begin
      stat_value = {4'b0, temp_r[stat_tidx[1:0]]};
    end
  end

  // the second byte only exists inside a read
  a_seen_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
    bytes_seen_r |-> read_busy_r)
    else $error("byte pending with no read in progress");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    (SW+1)'(sensor_step_r) < (SW+1)'(TOTAL))
    else $error("sensor step beyond the sensor list");

endmodule

`default_nettype wire

>>> rtl/psps_out.sv
`timescale 1ns / 1ps
`default_nettype none

module psps_out #(
  parameter int FINGER_SENSORS = 4
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   load,
  input  psps_pkg::psps_desc_t  desc,
  input  wire  [15:0]           stat_value,
  output logic [3:0]            stat_idx,
  output logic                  free,
  output logic                  out_tvalid,
  input  wire                   out_tready,
  output logic [psps_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                  out_tuser,
  output logic                  out_tlast
);
  import psps_pkg::*;

  localparam logic [3:0] RUN_LAST = 4'(FINGER_SENSORS + LOGIC_SENSORS + TEMP_SLOTS - 1);

  logic       out_valid_r;
  logic       out_status_r;
  logic [6:0] out_addr_r;
  logic [7:0] out_reg_r;
  logic [3:0] out_cnt_r;
  logic       cur_last;
  logic       fire;
  logic [3:0] st_index;
  logic [15:0] st_value;

  assign cur_last = !out_status_r || (out_cnt_r == RUN_LAST);
  assign fire     = out_valid_r && out_tready;
  assign free     = !out_valid_r || (out_tready && cur_last);
  assign stat_idx = out_cnt_r;

  // result register; a status run steps its index once per transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      out_status_r <= 1'b0;
      out_cnt_r    <= '0;
    end else if (fire && !cur_last) begin
      out_cnt_r <= out_cnt_r + 4'd1;
    end else begin
      if (fire) out_valid_r <= 1'b0;
      if (load && desc.act) begin
        out_valid_r  <= 1'b1;
        out_status_r <= desc.status;
        out_cnt_r    <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && desc.act) begin
      out_addr_r <= desc.status ? 7'd0 : desc.addr;
      out_reg_r  <= desc.status ? 8'd0 : desc.reg_idx;
    end
  end

  // result fields
  assign st_index   = out_status_r ? out_cnt_r : 4'd0;
  assign st_value   = out_status_r ? stat_value : 16'd0;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = cur_last;
  assign out_tdata  = {5'b0, st_value, st_index, out_reg_r, out_addr_r};

  a_run_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_cnt_r <= RUN_LAST))
    else $error("status index past end of run");

  a_cmd_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_status_r) |-> (out_cnt_r == 4'd0))
    else $error("read command with nonzero run index");

  a_run_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !cur_last) |=> (out_valid_r && out_status_r &&
      out_cnt_r == $past(out_cnt_r) + 4'd1))
    else $error("status run did not advance");

endmodule

`default_nettype wire

>>> rtl/power_sensor_poll_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake          payload
// in_       in   tvalid/tready      tuser: kind; tdata: rx_byte, adc_channel, adc_value
// out_      out  tvalid/tready      tuser: result_kind; tlast: last;
//                                   tdata: device_address, register_index,
//                                   status_index, status_value
// cfg_      in   psel/penable       autosend_period at byte address 0
//
// one item per cycle while neither out_tready nor a status run holds it: an item goes
// from the input register through the state update into the result register
// a read command is one output word; a status run is FINGER_SENSORS + 6
// output words, one word per transaction, and holds the input register meanwhile
// reset is synchronous on rst_n low and clears control and measurement state and
// the period register, not the input item or result address fields; out_tready low
// stalls the result register and, once the input register is full, drops in_tready

module power_sensor_poll_sequencer #(
  parameter int POLL_DIVIDER   = psps_pkg::POLL_DIVIDER_DEF,
  parameter int FINGER_SENSORS = psps_pkg::FINGER_SENSORS_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  // [7:0] rx_byte, [9:8] adc_channel, [21:10] adc_value, [23:22] zero
  input  wire  [psps_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [1:0] kind
  input  wire  [1:0]                          in_tuser,
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  // [6:0] device_address, [14:7] register_index, [18:15] status_index,
  // [34:19] status_value, [39:35] zero
  output logic [psps_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // [0] result_kind
  output logic                                out_tuser,
  output logic                                out_tlast,
  input  wire                                 cfg_psel,
  input  wire                                 cfg_penable,
  input  wire                                 cfg_pwrite,
  input  wire  [psps_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  wire  [psps_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [psps_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);
  import psps_pkg::*;

  logic        s1_valid_r;
  psps_item_t  s1_item_r;
  logic [15:0] autosend_r;
  logic        consume;
  logic        free;
  logic        cfg_wr;
  psps_desc_t  desc;
  logic [3:0]  stat_idx;
  logic [15:0] stat_value;

  // configuration register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr[2];
  assign cfg_prdata = cfg_paddr[2] ? '0 : {16'b0, autosend_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      autosend_r <= '0;
    end else if (cfg_wr) begin
      autosend_r <= cfg_pwdata[15:0];
    end
  end

  // input register
  assign consume   = s1_valid_r && free;
  assign in_tready = !s1_valid_r || free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_item_r.kind        <= psps_kind_t'(in_tuser);
      s1_item_r.rx_byte     <= in_tdata[7:0];
      s1_item_r.adc_channel <= in_tdata[9:8];
      s1_item_r.adc_value   <= in_tdata[21:10];
    end
  end

  psps_core #(
    .POLL_DIVIDER   (POLL_DIVIDER),
    .FINGER_SENSORS (FINGER_SENSORS)
  ) u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .autosend_period (autosend_r),
    .item            (s1_item_r),
    .consume         (consume),
    .desc            (desc),
    .stat_idx        (stat_idx),
    .stat_value      (stat_value)
  );

  psps_out #(
    .FINGER_SENSORS (FINGER_SENSORS)
  ) u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (consume),
    .desc       (desc),
    .stat_value (stat_value),
    .stat_idx   (stat_idx),
    .free       (free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire
